/* sv/three_level_priority_queue_defines.svh */
// Assertion macros for the three level priority queue.
// Included by the RTL files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define TLPQ_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("tlpq assertion failed");
// Check that a condition implies another in the same cycle.
`define TLPQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlpq implication failed");
`else
`define TLPQ_ASSERT(lbl, cond)
`define TLPQ_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* sv/tlpq_pkg.sv */
// Shared types and codes of the three level priority queue.
// No dependencies; imported by the interfaces, controller, datapath and top level.
package tlpq_pkg;

    localparam int LEVELS = 3;

    typedef logic [1:0] t_level;
    typedef logic [1:0] t_status;
    typedef logic [7:0] t_byte;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam t_level LEVEL_NONE = 2'd0;
    localparam t_level LEVEL_1    = 2'd1;
    localparam t_level LEVEL_2    = 2'd2;
    localparam t_level LEVEL_3    = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_INVALID = 2'd2;
    localparam t_status ST_EMPTY   = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_stall;
    } t_dp_sts;

endpackage

/* sv/tlpq_if.sv */
// Valid/ready channel interfaces for request items and result items.
// Depends on tlpq_pkg for the payload types.
interface tlpq_in_if import tlpq_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   kind;
    t_byte  value;
    t_level priority_req;

    modport source (output valid, output kind, output value, output priority_req, input ready);
    modport sink   (input valid, input kind, input value, input priority_req, output ready);
endinterface

interface tlpq_out_if import tlpq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_byte   value_res;
    t_level  served_level;
    t_status status;

    modport source (output valid, output value_res, output served_level, output status,
                    input ready);
    modport sink   (input valid, input value_res, input served_level, input status,
                    output ready);
endinterface

/* sv/tlpq_ctrl.sv */
// Sequencing state machine of the three level priority queue.
// Depends on tlpq_pkg; drives datapath commands, reads datapath status.
module tlpq_ctrl import tlpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_state <= S_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // hold until the output register is free
                    if (!i_sts.out_stall) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load_item = (r_state == S_IDLE) && i_in_valid && r_ready;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.load_out  = (r_state == S_RESP) && !i_sts.out_stall;
    end

    assign o_in_ready = r_ready;

endmodule

/* sv/tlpq_dp.sv */
// Datapath of the three level priority queue: ring store, pointers, counters, output register.
// Depends on tlpq_pkg and the assertion macros in three_level_priority_queue_defines.svh.
`include "three_level_priority_queue_defines.svh"
module tlpq_dp import tlpq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    input  logic    i_kind,
    input  t_byte   i_value,
    input  t_level  i_priority_req,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_byte   o_value_res,
    output t_level  o_served_level,
    output t_status o_status
);

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int WORDS  = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [OCC_W-1:0]  t_occ;
    typedef logic [ADDR_W-1:0] t_addr;

    // latched request item
    logic   r_kind;
    t_byte  r_value;
    t_level r_prio;

    t_slot  r_head [LEVELS];
    t_slot  r_tail [LEVELS];
    t_occ   r_occ  [LEVELS];

    t_byte  r_store [WORDS];
    t_byte  r_rd_data;

    // decision made in the execute cycle
    t_level  r_res_level;
    t_status r_res_status;
    logic    r_res_data;

    logic    r_out_valid;
    t_byte   r_out_value;
    t_level  r_out_level;
    t_status r_out_status;

    logic [1:0] sel_q;
    logic       do_write;
    logic       do_read;
    t_level     n_level;
    t_status    n_status;
    t_addr      wr_addr;
    t_addr      rd_addr;

    function automatic t_slot next_slot(input t_slot s);
        return (s == t_slot'(DEPTH - 1)) ? '0 : t_slot'(s + 1'b1);
    endfunction

    function automatic t_addr slot_addr(input logic [1:0] q, input t_slot s);
        t_addr a;
        case (q)
            2'd1:    a = t_addr'(DEPTH) + t_addr'(s);
            2'd2:    a = t_addr'(2 * DEPTH) + t_addr'(s);
            default: a = t_addr'(s);
        endcase
        return a;
    endfunction

    // pick the level and outcome of the latched item
    always_comb begin
        sel_q    = 2'd0;
        do_write = 1'b0;
        do_read  = 1'b0;
        n_level  = LEVEL_NONE;
        n_status = ST_OK;
        if (r_kind == KIND_INSERT) begin
            case (r_prio)
                LEVEL_1: sel_q = 2'd0;
                LEVEL_2: sel_q = 2'd1;
                LEVEL_3: sel_q = 2'd2;
                default: sel_q = 2'd0;
            endcase
            if (r_prio == LEVEL_NONE) begin
                n_status = ST_INVALID;
            end else begin
                n_level = r_prio;
                if (r_occ[sel_q] == t_occ'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    do_write = 1'b1;
                end
            end
        end else begin
            if (r_occ[0] != '0) begin
                sel_q   = 2'd0;
                n_level = LEVEL_1;
                do_read = 1'b1;
            end else if (r_occ[1] != '0) begin
                sel_q   = 2'd1;
                n_level = LEVEL_2;
                do_read = 1'b1;
            end else if (r_occ[2] != '0) begin
                sel_q   = 2'd2;
                n_level = LEVEL_3;
                do_read = 1'b1;
            end else begin
                n_status = ST_EMPTY;
            end
        end
    end

    assign wr_addr = slot_addr(sel_q, r_tail[sel_q]);
    assign rd_addr = slot_addr(sel_q, r_head[sel_q]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            r_store[wr_addr] <= r_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_prio  <= i_priority_req;
        end
        if (i_cmd.exec) begin
            r_res_level  <= n_level;
            r_res_status <= n_status;
            r_res_data   <= do_read;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_res_data ? r_rd_data : '0;
            r_out_level  <= r_res_level;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_occ[i]  <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec && do_write) begin
                r_tail[sel_q] <= next_slot(r_tail[sel_q]);
                r_occ[sel_q]  <= t_occ'(r_occ[sel_q] + 1'b1);
            end
            if (i_cmd.exec && do_read) begin
                r_head[sel_q] <= next_slot(r_head[sel_q]);
                r_occ[sel_q]  <= t_occ'(r_occ[sel_q] - 1'b1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_value_res     = r_out_value;
    assign o_served_level  = r_out_level;
    assign o_status        = r_out_status;

    `TLPQ_ASSERT(a_occ_l1, r_occ[0] <= t_occ'(DEPTH))
    `TLPQ_ASSERT(a_occ_l2, r_occ[1] <= t_occ'(DEPTH))
    `TLPQ_ASSERT(a_occ_l3, r_occ[2] <= t_occ'(DEPTH))
    `TLPQ_ASSERT_IMPL(a_no_overwrite, i_cmd.load_out, !(r_out_valid && !i_out_ready))
    `TLPQ_ASSERT_IMPL(a_rw_excl, i_cmd.exec, !(do_write && do_read))

endmodule

/* sv/three_level_priority_queue.sv */
// Three level priority queue of bytes: one ring FIFO of DEPTH entries per level, level 1 first.
// From the accepting edge the item passes the execute step with store access, then the result load.
// The controller accepts no new item until its sequence around the single registered store
// read is done; a stalled result register holds the sequence in its last step.
// Reset (synchronous, active low) empties all levels and the result register at once;
// store contents stay undefined, and a value from an unwritten entry never reaches the output.
module three_level_priority_queue import tlpq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tlpq_in_if.sink        i_item,
    tlpq_out_if.source     o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: accept one item, run the execute step, load the result register.
    tlpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: rings, head/tail pointers, occupancy counters, and the result register
    // that decouples the next accept from a waiting result.
    tlpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_item.kind),
        .i_value        (i_item.value),
        .i_priority_req (i_item.priority_req),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_value_res    (o_res.value_res),
        .o_served_level (o_res.served_level),
        .o_status       (o_res.status)
    );

endmodule
